// ----- design/dcc_packet_queue_signal_generator_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the track signal encoder
// Shared property forms used by the encoder's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef DCC_PACKET_QUEUE_SIGNAL_GENERATOR_TOP_ASSERT_SVH
`define DCC_PACKET_QUEUE_SIGNAL_GENERATOR_TOP_ASSERT_SVH

// Condition holds at every clock edge out of reset
`define DPQ_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define DPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/dpq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpq_pkg
// Types, codes and frame helpers shared by the track signal encoder.
// ----------------------------------------------------------------------------
package dpq_pkg;

	// Item opcodes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	// Result status codes
	localparam logic [1:0] LOAD_ACCEPTED   = 2'd0;
	localparam logic [1:0] LOAD_QUEUE_FULL = 2'd1;
	localparam logic [1:0] LOAD_BAD_LENGTH = 2'd2;
	localparam logic [1:0] LOAD_STEP_ITEM  = 2'd3;

	// Configuration register indexes
	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_ONE_HALF_PERIOD  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ZERO_HALF_PERIOD = 2'd1;

	localparam logic [15:0] ONE_HALF_RESET  = 16'd58;
	localparam logic [15:0] ZERO_HALF_RESET = 16'd98;

	// Frame layout
	localparam logic [6:0] PREAMBLE_BITS = 7'd22;
	localparam logic [6:0] BITS_PER_SLOT = 7'd9;
	localparam logic [2:0] MAX_SLOTS     = 3'd6;
	localparam logic [2:0] MIN_LOAD_LEN  = 3'd2;
	localparam logic [2:0] MAX_LOAD_LEN  = 3'd5;

	typedef struct packed {
		logic       opcode;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] byte2;
		logic [7:0] byte3;
		logic [7:0] byte4;
		logic [2:0] byte_count;
		logic [7:0] repeat_count;
		logic       drain_queue;
	} item_t;

	typedef struct packed {
		logic [1:0]  load_status;
		logic        track_level;
		logic [15:0] half_period;
		logic        bit_value;
		logic        frame_start;
	} result_t;

	// Queued packet: frame bytes with checksum, frame byte count, repeats
	typedef struct packed {
		logic [7:0]  reps;
		logic [2:0]  nbytes;
		logic [47:0] bytes;
	} word_t;

	// Idle packet FF 00 FF, no repeats
	localparam word_t IDLE_WORD = '{reps: 8'd0, nbytes: 3'd3, bytes: 48'h0000_00FF_00FF};

	// Total bits of one frame
	function automatic logic [6:0] frame_bits(word_t w);
		logic [2:0] n;
		n = (w.nbytes > MAX_SLOTS) ? MAX_SLOTS : w.nbytes;
		return PREAMBLE_BITS + ({4'd0, n} * BITS_PER_SLOT);
	endfunction

	// Bit of the frame at a given index
	function automatic logic frame_bit(word_t w, logic [6:0] idx);
		logic [6:0] k;
		logic [2:0] slot;
		logic [6:0] pos;
		logic [7:0] b;
		logic       r;
		k = idx - PREAMBLE_BITS;
		slot = 3'd0;
		for (int s = 1; s <= 6; s++) begin
			if (k >= 7'(s * 9)) begin
				slot = 3'(s);
			end
		end
		pos = k - ({4'd0, slot} * BITS_PER_SLOT);
		b = 8'(w.bytes >> {slot, 3'b000});
		if (idx < PREAMBLE_BITS) begin
			r = 1'b1;
		end else if (slot >= MAX_SLOTS) begin
			r = 1'b1;
		end else if (pos == 7'd0) begin
			r = 1'b0;
		end else begin
			r = b[3'(4'd8 - pos[3:0])];
		end
		return r;
	endfunction

endpackage

// ----- design/dpq_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpq_store
// Packet queue memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dpq_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  dpq_pkg::word_t  wr_data,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output dpq_pkg::word_t  rd_data
);

	dpq_pkg::word_t mem [DEPTH];

	// Write a queued packet
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read the queue head, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- design/dcc_packet_queue_signal_generator_top.sv -----
// Track signal encoder with a packet queue. Each accepted request yields one
// result. In the accepting cycle the queue memory is read at the head; in the
// next the state is updated, a packet is written at the tail and the result
// enters the output register. If the result of the previous request is still
// waiting there, the new result is parked in a side register and no request
// is taken until the waiting result has been taken. The queue memory has
// registered read data. The memory is not cleared after reset; the head, tail
// and count registers are. Configuration writes are taken every cycle.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_packet_queue_signal_generator_top
// Packet queue, frame sequencer and half-wave timing for the track output.
// ----------------------------------------------------------------------------
`include "dcc_packet_queue_signal_generator_top_assert.svh"

module dcc_packet_queue_signal_generator_top #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  dpq_pkg::item_t                      item,
	output logic                                result_valid,
	input  logic                                result_ready,
	output dpq_pkg::result_t                    result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dpq_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [15:0]                         cfg_data
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_HOLD = 2'd2;

	logic [1:0]        state_q;
	dpq_pkg::item_t    item_q;
	logic [AW-1:0]     head_q, tail_q;
	logic [CW-1:0]     count_q;
	dpq_pkg::word_t    active_q;
	logic              active_valid_q;
	logic [6:0]        bit_index_q;
	logic [7:0]        repeats_left_q;
	logic              high_half_next_q;
	logic              last_bit_q;
	logic [15:0]       one_half_q, zero_half_q;
	dpq_pkg::result_t  result_q, hold_q;
	logic              result_valid_q;

	logic              accept;
	logic              out_free;
	logic              mem_wr, mem_rd;
	dpq_pkg::word_t    rd_word;

	// Next-state and result terms of the executing request
	dpq_pkg::result_t  res;
	logic              wr_req;
	logic [AW-1:0]     wr_addr;
	dpq_pkg::word_t    load_word;
	logic [AW-1:0]     nxt_head, nxt_tail;
	logic [CW-1:0]     nxt_count;
	dpq_pkg::word_t    nxt_active;
	logic              nxt_active_valid;
	logic [6:0]        nxt_bit_index;
	logic [7:0]        nxt_repeats;
	logic              nxt_high_half;
	logic              nxt_last_bit;
	logic [4:0][7:0]   in_bytes;
	logic [7:0]        chk;
	logic [2:0]        n;
	logic [AW-1:0]     base_head, base_tail;
	logic [CW-1:0]     base_count;
	logic              finished, fetch;
	dpq_pkg::word_t    cur_word;
	logic [6:0]        cur_idx;
	logic              bitv;

	assign accept       = item_valid && item_ready;
	assign item_ready   = (state_q == S_IDLE);
	assign out_free     = !result_valid_q || result_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign cfg_ready    = 1'b1;
	assign mem_rd       = accept;
	assign mem_wr       = (state_q == S_EXEC) && wr_req;

	dpq_store #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (mem_wr),
		.wr_addr (wr_addr),
		.wr_data (load_word),
		.rd_en   (mem_rd),
		.rd_addr (head_q),
		.rd_data (rd_word)
	);

	// Build the packet word and its checksum from the held request
	always_comb begin
		in_bytes = {item_q.byte4, item_q.byte3, item_q.byte2, item_q.byte1, item_q.byte0};
		n = item_q.byte_count;
		chk = 8'd0;
		load_word = '0;
		for (int i = 0; i < 5; i++) begin
			if (3'(i) < n) begin
				chk = chk ^ in_bytes[i];
				load_word.bytes[i*8 +: 8] = in_bytes[i];
			end
		end
		if (n <= dpq_pkg::MAX_LOAD_LEN) begin
			load_word.bytes[{n, 3'b000} +: 8] = chk;
		end
		load_word.nbytes = n + 3'd1;
		load_word.reps = item_q.repeat_count;
	end

	// Decide queue, frame and result for the held request
	always_comb begin
		res = '0;
		wr_req = 1'b0;
		nxt_head = head_q;
		nxt_tail = tail_q;
		nxt_count = count_q;
		nxt_active = active_q;
		nxt_active_valid = active_valid_q;
		nxt_bit_index = bit_index_q;
		nxt_repeats = repeats_left_q;
		nxt_high_half = high_half_next_q;
		nxt_last_bit = last_bit_q;
		base_head = item_q.drain_queue ? '0 : head_q;
		base_tail = item_q.drain_queue ? '0 : tail_q;
		base_count = item_q.drain_queue ? '0 : count_q;
		wr_addr = base_tail;
		finished = active_valid_q && (bit_index_q >= dpq_pkg::frame_bits(active_q));
		fetch = !active_valid_q || (finished && (repeats_left_q == 8'd0));
		cur_word = active_q;
		cur_idx = bit_index_q;
		if (fetch) begin
			cur_word = (count_q != '0) ? rd_word : dpq_pkg::IDLE_WORD;
			cur_idx = 7'd0;
		end else if (finished) begin
			cur_idx = 7'd0;
		end
		bitv = dpq_pkg::frame_bit(cur_word, cur_idx);

		if (item_q.opcode == dpq_pkg::OP_LOAD) begin
			if ((n < dpq_pkg::MIN_LOAD_LEN) || (n > dpq_pkg::MAX_LOAD_LEN)) begin
				res.load_status = dpq_pkg::LOAD_BAD_LENGTH;
			end else begin
				nxt_head = base_head;
				nxt_tail = base_tail;
				nxt_count = base_count;
				if (base_count >= CW'(QUEUE_DEPTH)) begin
					res.load_status = dpq_pkg::LOAD_QUEUE_FULL;
				end else begin
					res.load_status = dpq_pkg::LOAD_ACCEPTED;
					wr_req = 1'b1;
					nxt_tail = (base_tail == AW'(QUEUE_DEPTH - 1)) ? '0 : base_tail + 1'b1;
					nxt_count = base_count + 1'b1;
				end
			end
		end else if (high_half_next_q) begin
			// Advance the frame, restart on a repeat, fetch when done
			if (fetch) begin
				if (count_q != '0) begin
					nxt_head = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
					nxt_count = count_q - 1'b1;
				end
				nxt_repeats = cur_word.reps;
			end else if (finished) begin
				nxt_repeats = repeats_left_q - 8'd1;
			end
			nxt_active = cur_word;
			nxt_active_valid = 1'b1;
			nxt_bit_index = cur_idx + 7'd1;
			nxt_last_bit = bitv;
			nxt_high_half = 1'b0;
			res.load_status = dpq_pkg::LOAD_STEP_ITEM;
			res.track_level = 1'b1;
			res.bit_value = bitv;
			res.half_period = bitv ? one_half_q : zero_half_q;
			res.frame_start = (cur_idx == 7'd0);
		end else begin
			// Low half repeats the last bit
			nxt_high_half = 1'b1;
			res.load_status = dpq_pkg::LOAD_STEP_ITEM;
			res.bit_value = last_bit_q;
			res.half_period = last_bit_q ? one_half_q : zero_half_q;
		end
	end

	// Hold the request payload and park a result the output register cannot take
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		if ((state_q == S_EXEC) && !out_free) begin
			hold_q <= res;
		end
	end

	// Sequencer, queue pointers, frame state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			active_q <= '0;
			active_valid_q <= 1'b0;
			bit_index_q <= 7'd0;
			repeats_left_q <= 8'd0;
			high_half_next_q <= 1'b1;
			last_bit_q <= 1'b1;
			result_valid_q <= 1'b0;
			result_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					// Drop the result once it is taken
					if (result_ready) begin
						result_valid_q <= 1'b0;
					end
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					head_q <= nxt_head;
					tail_q <= nxt_tail;
					count_q <= nxt_count;
					active_q <= nxt_active;
					active_valid_q <= nxt_active_valid;
					bit_index_q <= nxt_bit_index;
					repeats_left_q <= nxt_repeats;
					high_half_next_q <= nxt_high_half;
					last_bit_q <= nxt_last_bit;
					if (out_free) begin
						result_q <= res;
						result_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (out_free) begin
						result_q <= hold_q;
						result_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					result_valid_q <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_half_q <= dpq_pkg::ONE_HALF_RESET;
			zero_half_q <= dpq_pkg::ZERO_HALF_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == dpq_pkg::REG_ONE_HALF_PERIOD) begin
				one_half_q <= cfg_data;
			end
			if (cfg_index == dpq_pkg::REG_ZERO_HALF_PERIOD) begin
				zero_half_q <= cfg_data;
			end
		end
	end

	// Checks
	`DPQ_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CW'(QUEUE_DEPTH), "queue count over depth")
	`DPQ_ASSERT_ALWAYS(a_no_rw_overlap, clk, arst_n, !(mem_wr && mem_rd), "queue read and write overlap")
	`DPQ_ASSERT_ALWAYS(a_empty_ptrs, clk, arst_n, (count_q != '0) || (head_q == tail_q), "empty queue with split pointers")
	`DPQ_ASSERT_NEXT(a_accept_exec, clk, arst_n, accept, state_q == S_EXEC, "accepted request not executed")
	`DPQ_ASSERT_NEXT(a_high_half, clk, arst_n, (state_q == S_EXEC) && (item_q.opcode == dpq_pkg::OP_STEP) && high_half_next_q, !high_half_next_q && active_valid_q, "high half left no active frame")

endmodule
